/* sv/fsba_pkg.sv */
// ----------------------------------------------------------------------------
// fsba_pkg
// shared types and constants of the fixed slot bitmap allocator
// ----------------------------------------------------------------------------
package fsba_pkg;

    localparam int ADDR_W    = 32;
    localparam int BYTES_W   = 16;
    localparam int COUNT_W   = 7;
    localparam int INDEX_W   = 6;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        FUNC_ALLOC    = 2'd0,
        FUNC_FREE     = 2'd1,
        FUNC_FREE_ALL = 2'd2,
        FUNC_NONE     = 2'd3
    } func_t;

    localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

    typedef struct packed {
        logic accept;
        logic clear_all;
        logic res_fail;
        logic res_clear_ok;
        logic scan_init;
        logic scan_step;
        logic div_start;
        logic take_scan;
        logic take_div;
        logic mul;
        logic commit;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic  zero_size;
        func_t func;
        logic  alloc_room;
        logic  free_pre;
        logic  scan_hit;
        logic  scan_last;
        logic  div_done;
        logic  div_hit;
        logic  out_free;
    } stat_t;

endpackage

/* sv/fsba_div.sv */
// ----------------------------------------------------------------------------
// fsba_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fsba_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [fsba_pkg::ADDR_W-1:0]  dividend,
    input  logic [fsba_pkg::BYTES_W-1:0] divisor,
    output logic                         done,
    output logic [fsba_pkg::ADDR_W-1:0]  quotient
);
    import fsba_pkg::*;

    localparam int CW = $clog2(ADDR_W);

    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [BYTES_W-1:0] rem_reg, rem_next;
    logic [ADDR_W-1:0]  quo_reg, quo_next;
    logic [BYTES_W:0]   trial;
    logic [BYTES_W:0]   diff;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, quo_reg[ADDR_W-1]};
        diff      = trial - {1'b0, divisor};
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CW'(ADDR_W - 1);
            rem_next = '0;
            quo_next = dividend;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff[BYTES_W-1:0];
                quo_next = {quo_reg[ADDR_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[BYTES_W-1:0];
                quo_next = {quo_reg[ADDR_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* sv/fsba_dp.sv */
// ----------------------------------------------------------------------------
// fsba_dp
// datapath: configuration, used map, free slot scan, divider, address
// multiply and the result register
// ----------------------------------------------------------------------------
module fsba_dp #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [fsba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fsba_pkg::ADDR_W-1:0]    cfg_data,
    input  logic [1:0]                     func,
    input  logic [fsba_pkg::ADDR_W-1:0]    free_address,
    input  fsba_pkg::cmd_t                 cmd,
    output fsba_pkg::stat_t                stat,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           ok,
    output logic [fsba_pkg::ADDR_W-1:0]    slot_address,
    output logic [fsba_pkg::INDEX_W-1:0]   slot_index,
    output logic [fsba_pkg::COUNT_W-1:0]   active_slots
);
    import fsba_pkg::*;

    localparam int CAP   = (1 << COUNT_W) - 1;
    localparam int MAP_D = (MAX_SLOTS > CAP) ? CAP : MAX_SLOTS;
    localparam int IW    = (MAP_D > 1) ? $clog2(MAP_D) : 1;
    localparam int NCH   = (MAP_D + 7) / 8;
    localparam int CHW   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PW    = IW + BYTES_W;

    logic [ADDR_W-1:0]  base_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [MAP_D-1:0]   used_reg, used_next;
    logic [COUNT_W-1:0] active_reg, active_next;
    func_t              func_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [CHW-1:0]     chunk_reg;
    logic [IW-1:0]      idx_reg;
    logic [PW-1:0]      prod_reg;
    logic               res_ok_reg;
    logic [ADDR_W-1:0]  res_addr_reg;
    logic [IW-1:0]      res_idx_reg;
    logic               out_valid_reg, out_valid_next;
    logic               ok_reg;
    logic [ADDR_W-1:0]  addr_out_reg;
    logic [INDEX_W-1:0] index_out_reg;
    logic [COUNT_W-1:0] active_out_reg;

    logic [COUNT_W-1:0] size;
    logic [NCH*8-1:0]   avail;
    logic [7:0]         window;
    logic [2:0]         enc;
    logic               div_done;
    logic [ADDR_W-1:0]  quo;

    assign size = (count_reg > COUNT_W'(MAP_D)) ? COUNT_W'(MAP_D) : count_reg;

    // free slots below the pool size, padded to whole chunks
    always_comb
    begin
        avail = '0;
        for (int i = 0; i < MAP_D; i++)
        begin
            avail[i] = !used_reg[i] && (8'(i) < {1'b0, size});
        end
    end

    assign window = avail[{chunk_reg, 3'b000} +: 8];

    always_comb
    begin
        enc = '0;
        for (int j = 7; j >= 0; j--)
        begin
            if (window[j])
            begin
                enc = 3'(j);
            end
        end
    end

    fsba_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (addr_reg - base_reg),
        .divisor  (bytes_reg),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb
    begin
        stat.zero_size  = (bytes_reg == '0);
        stat.func       = func_reg;
        stat.alloc_room = (active_reg < size);
        stat.free_pre   = (addr_reg != '0) && (active_reg != '0) && (addr_reg >= base_reg);
        stat.scan_hit   = |window;
        stat.scan_last  = (chunk_reg == CHW'(NCH - 1));
        stat.div_done   = div_done;
        stat.div_hit    = (quo < ADDR_W'(size)) && used_reg[quo[IW-1:0]];
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    // used map and active count
    always_comb
    begin
        used_next   = used_reg;
        active_next = active_reg;
        if (cfg_write && (cfg_index == REG_COUNT))
        begin
            used_next   = '0;
            active_next = '0;
        end
        else if (cmd.clear_all)
        begin
            used_next   = '0;
            active_next = '0;
        end
        else if (cmd.commit)
        begin
            if (func_reg == FUNC_ALLOC)
            begin
                used_next[idx_reg] = 1'b1;
                active_next        = active_reg + 1'b1;
            end
            else
            begin
                used_next[idx_reg] = 1'b0;
                active_next        = active_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            bytes_reg     <= '0;
            count_reg     <= '0;
            used_reg      <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && (cfg_index == REG_BASE))
            begin
                base_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == REG_BYTES))
            begin
                bytes_reg <= cfg_data[BYTES_W-1:0];
            end
            if (cfg_write && (cfg_index == REG_COUNT))
            begin
                count_reg <= cfg_data[COUNT_W-1:0];
            end
            used_reg      <= used_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg <= func_t'(func);
            addr_reg <= free_address;
        end
        if (cmd.scan_init)
        begin
            chunk_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            chunk_reg <= chunk_reg + 1'b1;
        end
        if (cmd.take_scan)
        begin
            idx_reg <= IW'({chunk_reg, enc});
        end
        else if (cmd.take_div)
        begin
            idx_reg <= quo[IW-1:0];
        end
        if (cmd.mul)
        begin
            prod_reg <= PW'(idx_reg) * PW'(bytes_reg);
        end
        if (cmd.res_fail || cmd.res_clear_ok)
        begin
            res_ok_reg   <= cmd.res_clear_ok;
            res_addr_reg <= '0;
            res_idx_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            res_ok_reg   <= 1'b1;
            res_addr_reg <= base_reg + ADDR_W'(prod_reg);
            res_idx_reg  <= idx_reg;
        end
        if (cmd.load_out)
        begin
            ok_reg         <= res_ok_reg;
            addr_out_reg   <= res_addr_reg;
            index_out_reg  <= INDEX_W'(res_idx_reg);
            active_out_reg <= active_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign ok           = ok_reg;
    assign slot_address = addr_out_reg;
    assign slot_index   = index_out_reg;
    assign active_slots = active_out_reg;

endmodule

/* sv/fsba_ctrl.sv */
// ----------------------------------------------------------------------------
// fsba_ctrl
// request sequencer: decode, scan or divide, multiply, commit, hand off
// ----------------------------------------------------------------------------
module fsba_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  fsba_pkg::stat_t stat,
    output fsba_pkg::cmd_t  cmd
);
    import fsba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_DIV,
        S_MUL,
        S_COMMIT,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   stall_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FIN;
                if (stat.zero_size)
                begin
                    cmd.res_fail = 1'b1;
                end
                else
                begin
                    case (stat.func)
                        FUNC_ALLOC:
                        begin
                            if (stat.alloc_room)
                            begin
                                cmd.scan_init = 1'b1;
                                state_next    = S_SCAN;
                            end
                            else
                            begin
                                cmd.res_fail = 1'b1;
                            end
                        end
                        FUNC_FREE:
                        begin
                            if (stat.free_pre)
                            begin
                                cmd.div_start = 1'b1;
                                state_next    = S_DIV;
                            end
                            else
                            begin
                                cmd.res_fail = 1'b1;
                            end
                        end
                        FUNC_FREE_ALL:
                        begin
                            cmd.clear_all    = 1'b1;
                            cmd.res_clear_ok = 1'b1;
                        end
                        default:
                        begin
                            cmd.res_fail = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (stat.scan_hit)
                begin
                    cmd.take_scan = 1'b1;
                    state_next    = S_MUL;
                end
                else if (stat.scan_last)
                begin
                    cmd.res_fail = 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    if (stat.div_hit)
                    begin
                        cmd.take_div = 1'b1;
                        state_next   = S_MUL;
                    end
                    else
                    begin
                        cmd.res_fail = 1'b1;
                        state_next   = S_FIN;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= (state_next != S_IDLE);
        end
    end

    assign in_stall = stall_reg;

endmodule

/* sv/fixed_slot_bitmap_allocator.sv */
// ----------------------------------------------------------------------------
// fixed_slot_bitmap_allocator
// a free divides in the serial divider (rejected when the divided slot is out of
// range or not in use), an allocate scans the map (8-slot scan per cycle), free
// all and early rejects go straight to the result; one request at a time, next
// beat accepted in the cycle after the result loads unless the previous result
// is stalled
// reset clears configuration, used map and active count at once
// ----------------------------------------------------------------------------
module fixed_slot_bitmap_allocator #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [fsba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fsba_pkg::ADDR_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     func,
    input  logic [fsba_pkg::ADDR_W-1:0]    free_address,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           ok,
    output logic [fsba_pkg::ADDR_W-1:0]    slot_address,
    output logic [fsba_pkg::INDEX_W-1:0]   slot_index,
    output logic [fsba_pkg::COUNT_W-1:0]   active_slots
);
    import fsba_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    fsba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    fsba_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .func         (func),
        .free_address (free_address),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ok           (ok),
        .slot_address (slot_address),
        .slot_index   (slot_index),
        .active_slots (active_slots)
    );

`ifndef NO_ASSERTIONS
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || !out_stall))
        else $error("result register overwritten");

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("accepted beat without going busy");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (slot_address == '0 && slot_index == '0))
        else $error("failed result carries a slot");

    a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (stat.zero_size == $past(stat.zero_size)))
        else $error("slot size changed during a request");
`endif

endmodule

/* bench/fsba_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fsba_checker
// Watches the request, result and register-write ports of the slot allocator.
// Keeps its own copy of the used map, active count and pool registers, works
// out the result of every accepted request and compares each result beat
// against the oldest outstanding prediction. Failures and the number of
// results still awaited are handed to the test top.
// ----------------------------------------------------------------------------
module fsba_checker #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [fsba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fsba_pkg::ADDR_W-1:0]    cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  fsba_pkg::func_t                func,
    input  logic [fsba_pkg::ADDR_W-1:0]    free_address,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic                           ok,
    input  logic [fsba_pkg::ADDR_W-1:0]    slot_address,
    input  logic [fsba_pkg::INDEX_W-1:0]   slot_index,
    input  logic [fsba_pkg::COUNT_W-1:0]   active_slots,
    output int                             failures,
    output int                             outstanding
);
    import fsba_pkg::*;

    typedef struct packed {
        logic               ok;
        logic [ADDR_W-1:0]  addr;
        logic [INDEX_W-1:0] index;
        logic [COUNT_W-1:0] active;
    } grant_t;

    grant_t               awaited[$];
    logic [MAX_SLOTS-1:0] busy_map;
    logic [COUNT_W-1:0]   busy_total;
    logic [ADDR_W-1:0]    base_q;
    logic [BYTES_W-1:0]   bytes_q;
    logic [COUNT_W-1:0]   count_q;

    function automatic grant_t serve(func_t f, logic [ADDR_W-1:0] addr);
        grant_t            g;
        int unsigned       lim;
        logic [ADDR_W-1:0] q;
        bit                found;
        g = '0;
        found = 1'b0;
        lim = (count_q > MAX_SLOTS) ? MAX_SLOTS : count_q;
        if (bytes_q != '0)
        begin
            case (f)
                FUNC_ALLOC:
                begin
                    if (busy_total < lim)
                    begin
                        for (int i = 0; i < MAX_SLOTS; i++)
                        begin
                            if (!found && i < lim && !busy_map[i])
                            begin
                                found = 1'b1;
                                busy_map[i] = 1'b1;
                                busy_total = busy_total + 1'b1;
                                g.ok = 1'b1;
                                g.index = i[INDEX_W-1:0];
                                g.addr = base_q + ADDR_W'(i) * ADDR_W'(bytes_q);
                            end
                        end
                    end
                end
                FUNC_FREE:
                begin
                    if (addr != '0 && busy_total != '0 && addr >= base_q)
                    begin
                        q = (addr - base_q) / ADDR_W'(bytes_q);
                        if (q < lim && busy_map[q[INDEX_W-1:0]])
                        begin
                            busy_map[q[INDEX_W-1:0]] = 1'b0;
                            busy_total = busy_total - 1'b1;
                            g.ok = 1'b1;
                            g.index = q[INDEX_W-1:0];
                            g.addr = base_q + q * ADDR_W'(bytes_q);
                        end
                    end
                end
                FUNC_FREE_ALL:
                begin
                    busy_map = '0;
                    busy_total = '0;
                    g.ok = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        g.active = busy_total;
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        grant_t seen;
        grant_t want;
        if (!rst_n)
        begin
            awaited.delete();
            busy_map = '0;
            busy_total = '0;
            base_q = '0;
            bytes_q = '0;
            count_q = '0;
            failures = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = {ok, slot_address, slot_index, active_slots};
                if (awaited.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: result beat with no request pending: ok %0b addr %h",
                                 $realtime, ok, slot_address);
                end
                else
                begin
                    want = awaited.pop_front();
                    if (seen !== want)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display({"%0t: mismatch (expected/actual) ok %0b/%0b addr %h/%h",
                                      " index %0d/%0d active %0d/%0d"}, $realtime,
                                     want.ok, seen.ok, want.addr, seen.addr,
                                     want.index, seen.index, want.active, seen.active);
                    end
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_BASE:  base_q = cfg_data;
                    REG_BYTES: bytes_q = cfg_data[BYTES_W-1:0];
                    REG_COUNT:
                    begin
                        count_q = cfg_data[COUNT_W-1:0];
                        busy_map = '0;
                        busy_total = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
                awaited.push_back(serve(func, free_address));
            outstanding = awaited.size();
        end
    end

endmodule

/* bench/fixed_slot_bitmap_allocator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_slot_bitmap_allocator_test
// Drives allocate, free, free-all and unknown requests into the slot
// allocator: a directed opening over the corner cases, then randomized
// phases under several pool settings with random idling on both channels
// and one long result hold-off. The checker beside the block predicts and
// compares every result; this top gives the verdict.
// ----------------------------------------------------------------------------
module fixed_slot_bitmap_allocator_test;
    import fsba_pkg::*;

    localparam int MAX_SLOTS   = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 55;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    func_t                func;
    logic [ADDR_W-1:0]    free_address;
    logic                 out_valid;
    logic                 out_stall;
    logic                 ok;
    logic [ADDR_W-1:0]    slot_address;
    logic [INDEX_W-1:0]   slot_index;
    logic [COUNT_W-1:0]   active_slots;
    int                   failures;
    int                   outstanding;

    int                   cycles;
    bit                   calm;
    bit                   hold_pending;
    logic [ADDR_W-1:0]    pool_base;
    logic [BYTES_W-1:0]   pool_bytes;
    logic [COUNT_W-1:0]   pool_count;

    fixed_slot_bitmap_allocator #(.MAX_SLOTS(MAX_SLOTS)) u_dut (.*);

    fsba_checker #(.MAX_SLOTS(MAX_SLOTS)) u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // result side: random stall bursts, one long hold-off on request
    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_pending)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_pending = 1'b0;
            end
            else if (calm)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    function automatic int unsigned pool_limit();
        return (pool_count > MAX_SLOTS) ? MAX_SLOTS : pool_count;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr_of(int unsigned idx,
                                                      logic [ADDR_W-1:0] offset);
        return pool_base + ADDR_W'(idx) * ADDR_W'(pool_bytes) + offset;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_BASE:  pool_base = data;
            REG_BYTES: pool_bytes = data[BYTES_W-1:0];
            REG_COUNT: pool_count = data[COUNT_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send(input func_t f, input logic [ADDR_W-1:0] addr);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        free_address <= addr;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic random_request();
        int unsigned       pick;
        int unsigned       lim;
        logic [ADDR_W-1:0] offset;
        pick = $urandom_range(0, 99);
        lim = pool_limit();
        offset = (pool_bytes == '0) ? '0 : $urandom_range(0, pool_bytes - 1);
        if (pick < 42)
            send(FUNC_ALLOC, $urandom);
        else if (pick < 84)
            send(FUNC_FREE, slot_addr_of($urandom_range(0, lim), offset));
        else if (pick < 88)
            send(FUNC_FREE_ALL, $urandom);
        else if (pick < 92)
            send(FUNC_NONE, $urandom);
        else if (pick < 96)
            send(FUNC_FREE, $urandom);
        else if (pick < 98)
            send(FUNC_FREE, pool_base - $urandom_range(1, 16));
        else
            send(FUNC_FREE, '0);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= REG_BASE;
        cfg_data <= '0;
        in_valid <= 1'b0;
        func <= FUNC_ALLOC;
        free_address <= '0;
        calm = 1'b0;
        hold_pending = 1'b0;
        pool_base = '0;
        pool_bytes = '0;
        pool_count = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero slot size after reset
        send(FUNC_ALLOC, '0);
        send(FUNC_FREE, 32'h0000_1000);
        send(FUNC_FREE_ALL, '0);
        send(FUNC_NONE, '1);

        settle();
        write_reg(REG_BASE, 32'h0000_1000);
        write_reg(REG_BYTES, 32'h0000_0040);
        write_reg(REG_COUNT, 32'd4);
        repeat (5) send(FUNC_ALLOC, '0);
        send(FUNC_FREE, '0);
        send(FUNC_FREE, 32'h0000_0FFF);
        send(FUNC_FREE, 32'h0000_10BF);
        send(FUNC_FREE, 32'h0000_1080);
        send(FUNC_FREE, 32'h0000_1100);
        send(FUNC_NONE, 32'h0000_1000);
        send(FUNC_ALLOC, '0);
        send(FUNC_FREE_ALL, '0);
        send(FUNC_FREE, 32'h0000_1000);

        // oversized count and address wrap
        settle();
        write_reg(REG_BASE, 32'hFFFF_FF00);
        write_reg(REG_BYTES, 32'h0000_FFFF);
        write_reg(REG_COUNT, 32'h0000_007F);
        repeat (3) send(FUNC_ALLOC, '0);
        send(FUNC_FREE, 32'h0000_FEFF);
        send(FUNC_FREE, 32'hFFFF_FF10);

        // base change keeps the map
        settle();
        write_reg(REG_BASE, 32'h0000_2000);
        send(FUNC_FREE, 32'h0001_1FFF);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            case (phase)
                1:       write_reg(REG_BASE, '1);
                2:       write_reg(REG_BASE, '0);
                default: write_reg(REG_BASE, $urandom);
            endcase
            case (phase)
                3:       write_reg(REG_BYTES, 32'h0000_FFFF);
                4:       write_reg(REG_BYTES, 32'd1);
                5:       write_reg(REG_BYTES, '0);
                6:       write_reg(REG_BYTES, $urandom);
                default: write_reg(REG_BYTES, $urandom_range(1, 300));
            endcase
            case (phase)
                1, 7:    write_reg(REG_COUNT, 32'd64);
                8:       write_reg(REG_COUNT, 32'd127);
                2:       write_reg(REG_COUNT, 32'd0);
                4, 5, 6:
                begin
                end
                default: write_reg(REG_COUNT, $urandom_range(1, 10));
            endcase
            hold_pending = (phase == 3);
            calm = (phase == PHASES - 1);
            repeat (PHASE_ITEMS) random_request();
        end

        settle();
        if (failures == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
